/* design/dffr_pkg.sv */
// ----------------------------------------------------------------------------
// dffr_pkg
// Types and constants shared by the dual format frame receiver.
// ----------------------------------------------------------------------------
package dffr_pkg;

    typedef logic [7:0] t_byte;
    typedef logic [8:0] t_len;
    typedef logic [1:0] t_kind;

    // byte classification codes
    localparam t_kind KIND_JUNK  = 2'd0;
    localparam t_kind KIND_BIN   = 2'd1;
    localparam t_kind KIND_ASCII = 2'd2;
    localparam t_kind KIND_ERR   = 2'd3;

    localparam t_byte SOF_BIN    = 8'h0B;
    localparam t_byte SOF_ASCII  = 8'h2A;
    localparam t_byte DIGIT_ZERO = 8'h30;
    localparam t_byte DIGIT_ONE  = 8'h31;
    localparam t_byte DIGIT_NINE = 8'h39;

    localparam int RECORD_LEN  = 24;
    localparam int TRAILER_LEN = 4;

    typedef enum logic [1:0] {
        PH_HUNT  = 2'b01,
        PH_FRAME = 2'b10
    } t_phase;

    typedef struct packed {
        t_byte out_byte;
        t_kind byte_kind;
        logic  first_of_frame;
        logic  last_of_frame;
        t_len  frame_length;
        logic  checksum_good;
    } t_result;

endpackage

/* design/dffr_if.sv */
// ----------------------------------------------------------------------------
// dffr_if
// Valid/ready channels of the frame receiver: input bytes, results, config.
// ----------------------------------------------------------------------------
interface dffr_in_if;
    import dffr_pkg::*;
    logic  valid;
    logic  ready;
    t_byte in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface dffr_out_if;
    import dffr_pkg::*;
    logic  valid;
    logic  ready;
    t_byte out_byte;
    t_kind byte_kind;
    logic  first_of_frame;
    logic  last_of_frame;
    t_len  frame_length;
    logic  checksum_good;

    modport source (output valid, output out_byte, output byte_kind,
                    output first_of_frame, output last_of_frame,
                    output frame_length, output checksum_good, input ready);
    modport sink   (input valid, input out_byte, input byte_kind,
                    input first_of_frame, input last_of_frame,
                    input frame_length, input checksum_good, output ready);
endinterface

interface dffr_cfg_if;
    logic valid;
    logic ready;
    logic net_mode;

    modport source (output valid, output net_mode, input ready);
    modport sink   (input valid, input net_mode, output ready);
endinterface

/* design/dual_format_frame_receiver_unit.sv */
// ----------------------------------------------------------------------------
// dual_format_frame_receiver_unit
// Hunts a byte stream for binary (0x0B) and ASCII (0x2A) frames and tags
// every byte with its kind, frame bounds, length and checksum verdict.
// ----------------------------------------------------------------------------
// The result is registered at the edge that takes the byte.
// Throughput: 1 byte per cycle when not stalled; frame state is a closed loop.
// Input ready is held low only while a result waits and the sink is not ready.
// Reset (synchronous, active low): hunting, all sums and counters zero,
// net_mode 0, result register empty.
// ----------------------------------------------------------------------------
module dual_format_frame_receiver_unit #(
    parameter int BASIC_HEADER_LEN = 4,
    parameter int ASCII_HEADER_LEN = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dffr_cfg_if.sink    i_cfg,
    dffr_in_if.sink     i_in,
    dffr_out_if.source  o_out
);
    import dffr_pkg::*;

    logic    r_net_mode;
    logic    w_free;
    logic    w_accept;
    t_result w_result;

    // Config register is always writable; writes are expected only when idle.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_net_mode <= 1'b0;
        end else if (i_cfg.valid) begin
            r_net_mode <= i_cfg.net_mode;
        end
    end

    // A byte transaction completes whenever the result register has room,
    // including the cycle in which its current result is taken.
    assign i_in.ready = w_free;
    assign w_accept   = i_in.valid && w_free;

    // Frame tracking: state lives here, updated once per accepted byte.
    dffr_core #(
        .BASIC_HEADER_LEN (BASIC_HEADER_LEN),
        .ASCII_HEADER_LEN (ASCII_HEADER_LEN)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_byte     (i_in.in_byte),
        .i_net_mode (r_net_mode),
        .o_result   (w_result)
    );

    // Result register decouples the sink's stalls from the byte stream.
    dffr_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_accept),
        .i_result (w_result),
        .o_free   (w_free),
        .o_out    (o_out)
    );

endmodule

/* design/dffr_core.sv */
// ----------------------------------------------------------------------------
// dffr_core
// Frame tracking state and the per-byte update; one byte per accept.
// ----------------------------------------------------------------------------
module dffr_core #(
    parameter int BASIC_HEADER_LEN = 4,
    parameter int ASCII_HEADER_LEN = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  dffr_pkg::t_byte   i_byte,
    input  logic              i_net_mode,
    output dffr_pkg::t_result o_result
);
    import dffr_pkg::*;

    t_phase      r_phase, n_phase;
    logic        r_kind, n_kind;          // 1: ascii frame
    t_len        r_pos, n_pos;
    t_len        r_exp, n_exp;
    t_byte       r_bsum, n_bsum;
    logic [15:0] r_wsum, n_wsum;
    t_byte       r_tens, n_tens;
    t_byte       r_low, n_low;

    logic [9:0]  w_p1, w_p3, w_p4, w_p5, w_hlen, w_blen, w_alen, w_e;
    logic [4:0]  w_count;
    logic [15:0] w_wadd;
    logic        w_err;

    assign w_p1   = {1'b0, r_pos} + 10'd1;
    assign w_p3   = {1'b0, r_pos} + 10'd3;
    assign w_p4   = {1'b0, r_pos} + 10'd4;
    assign w_p5   = {1'b0, r_pos} + 10'd5;
    assign w_hlen = 10'(BASIC_HEADER_LEN) + {9'd0, i_net_mode};
    assign w_blen = w_hlen + {2'b00, i_byte};
    // tens digit is 0x30 or 0x31 once stored, so its low bit is the digit
    assign w_count = (r_tens[0] ? 5'd10 : 5'd0) + 5'(i_byte[3:0]);
    assign w_alen  = 10'(ASCII_HEADER_LEN) + 10'(TRAILER_LEN)
                   + 10'(w_count) * 10'(RECORD_LEN);

    always_comb begin
        n_phase = r_phase;
        n_kind  = r_kind;
        n_pos   = r_pos;
        n_exp   = r_exp;
        n_bsum  = r_bsum;
        n_wsum  = r_wsum;
        n_tens  = r_tens;
        n_low   = r_low;
        w_err   = 1'b0;
        w_e     = {1'b0, r_exp};
        w_wadd  = r_wsum;
        o_result = '0;
        o_result.out_byte = i_byte;

        case (r_phase)
            PH_HUNT: begin
                if (i_byte == SOF_BIN || i_byte == SOF_ASCII) begin
                    n_kind  = (i_byte == SOF_ASCII);
                    n_bsum  = i_byte;
                    n_wsum  = '0;
                    n_pos   = 9'd1;
                    n_exp   = '0;
                    n_phase = PH_FRAME;
                    o_result.byte_kind      = (i_byte == SOF_ASCII) ? KIND_ASCII : KIND_BIN;
                    o_result.first_of_frame = 1'b1;
                end
            end
            PH_FRAME: begin
                if (!r_kind) begin
                    o_result.byte_kind = KIND_BIN;
                    n_bsum = r_bsum + i_byte;
                    if (r_exp == '0 && w_p1 >= w_hlen) begin
                        w_e = {1'b0, w_blen[8:0]};
                    end
                    n_exp = w_e[8:0];
                    o_result.frame_length = w_e[8:0];
                    if (w_e != '0 && w_p1 >= w_e) begin
                        o_result.last_of_frame = 1'b1;
                        o_result.checksum_good = (n_bsum == '0);
                        n_phase = PH_HUNT;
                    end else begin
                        n_pos = w_p1[8:0];
                    end
                end else begin
                    o_result.byte_kind = KIND_ASCII;
                    if (r_pos == 9'd1) begin
                        if (i_byte < DIGIT_ZERO || i_byte > DIGIT_ONE) begin
                            w_err = 1'b1;
                        end else begin
                            n_tens = i_byte;
                        end
                    end else if (r_pos == 9'd2) begin
                        if (i_byte < DIGIT_ZERO || i_byte > DIGIT_NINE) begin
                            w_err = 1'b1;
                        end else begin
                            w_e = {1'b0, w_alen[8:0]};
                        end
                    end
                    if (w_err) begin
                        o_result.byte_kind = KIND_ERR;
                        n_phase = PH_HUNT;
                        n_exp   = '0;
                    end else begin
                        n_exp = w_e[8:0];
                        if (r_pos != '0 && (w_e == '0 || w_p5 <= w_e)) begin
                            w_wadd = r_wsum + {8'd0, i_byte};
                        end
                        n_wsum = w_wadd;
                        if (w_e != '0 && w_p4 == w_e) begin
                            n_low = i_byte;
                        end
                        if (w_e != '0 && w_p3 == w_e) begin
                            n_wsum = w_wadd - {i_byte, r_low};
                        end
                        o_result.frame_length = w_e[8:0];
                        if (w_e != '0 && w_p1 >= w_e) begin
                            o_result.last_of_frame = 1'b1;
                            o_result.checksum_good = (n_wsum == '0);
                            n_phase = PH_HUNT;
                        end else begin
                            n_pos = w_p1[8:0];
                        end
                    end
                end
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_kind  <= 1'b0;
            r_pos   <= '0;
            r_exp   <= '0;
            r_bsum  <= '0;
            r_wsum  <= '0;
            r_tens  <= '0;
            r_low   <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_kind  <= n_kind;
            r_pos   <= n_pos;
            r_exp   <= n_exp;
            r_bsum  <= n_bsum;
            r_wsum  <= n_wsum;
            r_tens  <= n_tens;
            r_low   <= n_low;
        end
    end

    // frame end always drops back to hunting
    a_last_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && o_result.last_of_frame |=> r_phase == PH_HUNT)
        else $error("frame end did not return to hunt");

    // start byte opens a frame at position one with unknown length
    a_first_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && o_result.first_of_frame
        |=> r_phase == PH_FRAME && r_pos == 9'd1 && r_exp == '0)
        else $error("start byte did not open a frame");

    // inside a frame the position never reaches a known length
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_FRAME && r_exp != '0 |-> r_pos < r_exp)
        else $error("byte position passed frame length");

    // count error aborts the frame without length or end flags
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && o_result.byte_kind == KIND_ERR
        |=> r_phase == PH_HUNT && r_exp == '0)
        else $error("count error did not abandon frame");

endmodule

/* design/dffr_out_reg.sv */
// ----------------------------------------------------------------------------
// dffr_out_reg
// Result register between the byte update and the result channel.
// ----------------------------------------------------------------------------
module dffr_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  dffr_pkg::t_result i_result,
    output logic              o_free,
    dffr_out_if.source        o_out
);
    import dffr_pkg::*;

    logic    r_valid;
    t_result r_result;

    // free when empty or the held result leaves this cycle
    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.out_byte       = r_result.out_byte;
    assign o_out.byte_kind      = r_result.byte_kind;
    assign o_out.first_of_frame = r_result.first_of_frame;
    assign o_out.last_of_frame  = r_result.last_of_frame;
    assign o_out.frame_length   = r_result.frame_length;
    assign o_out.checksum_good  = r_result.checksum_good;

endmodule

/* tb/dual_format_frame_receiver_unit_tb.sv */
// ----------------------------------------------------------------------------
// dual_format_frame_receiver_unit_tb
// Self-checking bench for the dual format frame receiver. A short table of
// directed bytes is followed by a random stream of binary and ASCII frames,
// broken frames and junk. net_mode changes between phases. Every result
// transaction is compared with a model of the byte tagger kept in the bench,
// or with the hand-written tag that the directed table gives for the byte.
module dual_format_frame_receiver_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dffr_pkg::*;

    localparam int BASIC_HEADER_LEN = 4;
    localparam int ASCII_HEADER_LEN = 8;
    localparam int CLK_PERIOD       = 8;
    localparam int RESET_CYCLES     = 5;
    localparam int TOTAL_ITEMS      = 1650;
    localparam int IDLE_PCT         = 17;
    localparam int QUIET_FROM       = 800;   // no idling on either side from here
    localparam int QUIET_TO         = 1100;
    localparam int HOLD_AT          = 850;   // sink holds off once, inside the quiet stretch
    localparam int HOLD_CYCLES      = 200;
    localparam int SETTLE_CYCLES    = 4;     // spare wait after the last owed tag
    localparam int STALL_LIMIT      = 2000;  // cycles with no transaction at all
    localparam int N_PLAN           = 21;

    // one directed byte: net_mode it runs under, the byte, and an optional
    // hand-written tag that replaces the model's prediction
    typedef struct packed {
        logic    mode;
        t_byte   data;
        logic    pinned;
        t_result val;
    } t_plan_row;

    typedef struct packed {
        logic    pinned;
        t_result val;
    } t_pin;

    logic clk = 1'b0;
    logic rst_n;

    dffr_cfg_if cfg_ch ();
    dffr_in_if  in_ch ();
    dffr_out_if out_ch ();

    dual_format_frame_receiver_unit #(
        .BASIC_HEADER_LEN(BASIC_HEADER_LEN),
        .ASCII_HEADER_LEN(ASCII_HEADER_LEN)
    ) u_dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_cfg  (cfg_ch),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------------
    // Directed table. Hand-written tags only where they are obvious: junk, start
    // bytes, count field errors, the empty binary frame, the ends of good frames.
    // ------------------------------------------------------------------------
    t_plan_row plan [N_PLAN] = '{
        // junk at both extremes of the byte
        '{1'b0, 8'h00, 1'b1, '{8'h00, KIND_JUNK, 1'b0, 1'b0, 9'd0, 1'b0}},
        '{1'b0, 8'hFF, 1'b1, '{8'hFF, KIND_JUNK, 1'b0, 1'b0, 9'd0, 1'b0}},
        // binary frame, empty payload: the length byte closes it, sum is zero
        '{1'b0, 8'h0B, 1'b1, '{8'h0B, KIND_BIN, 1'b1, 1'b0, 9'd0, 1'b0}},
        '{1'b0, 8'hF5, 1'b1, '{8'hF5, KIND_BIN, 1'b0, 1'b0, 9'd0, 1'b0}},
        '{1'b0, 8'h00, 1'b1, '{8'h00, KIND_BIN, 1'b0, 1'b0, 9'd0, 1'b0}},
        '{1'b0, 8'h00, 1'b1, '{8'h00, KIND_BIN, 1'b0, 1'b1, 9'd4, 1'b1}},
        // tens digit just below the digit range
        '{1'b0, 8'h2A, 1'b1, '{8'h2A, KIND_ASCII, 1'b1, 1'b0, 9'd0, 1'b0}},
        '{1'b0, 8'h2F, 1'b1, '{8'h2F, KIND_ERR, 1'b0, 1'b0, 9'd0, 1'b0}},
        // a start byte in the count field is an error, not a new frame
        '{1'b0, 8'h2A, 1'b1, '{8'h2A, KIND_ASCII, 1'b1, 1'b0, 9'd0, 1'b0}},
        '{1'b0, 8'h0B, 1'b1, '{8'h0B, KIND_ERR, 1'b0, 1'b0, 9'd0, 1'b0}},
        '{1'b0, 8'h00, 1'b1, '{8'h00, KIND_JUNK, 1'b0, 1'b0, 9'd0, 1'b0}},
        // good tens digit, units digit just above nine
        '{1'b0, 8'h2A, 1'b1, '{8'h2A, KIND_ASCII, 1'b1, 1'b0, 9'd0, 1'b0}},
        '{1'b0, 8'h31, 1'b0, '0},
        '{1'b0, 8'h3A, 1'b1, '{8'h3A, KIND_ERR, 1'b0, 1'b0, 9'd0, 1'b0}},
        // net mode: five byte header, length 2, good checksum
        '{1'b1, 8'h0B, 1'b1, '{8'h0B, KIND_BIN, 1'b1, 1'b0, 9'd0, 1'b0}},
        '{1'b1, 8'h01, 1'b0, '0},
        '{1'b1, 8'h02, 1'b0, '0},
        '{1'b1, 8'h03, 1'b0, '0},
        '{1'b1, 8'h02, 1'b0, '0},
        '{1'b1, 8'hFF, 1'b0, '0},
        '{1'b1, 8'hEE, 1'b1, '{8'hEE, KIND_BIN, 1'b0, 1'b1, 9'd7, 1'b1}}
    };

    // ------------------------------------------------------------------------
    // Bench model of the receiver state
    // ------------------------------------------------------------------------
    t_phase pr_phase;
    logic   pr_ascii;      // kind of the frame in progress
    t_len   pr_pos;        // index of the next frame byte
    t_len   pr_len;        // frame length, 0 while unknown
    t_byte  pr_bsum;       // binary running sum
    logic [15:0] pr_wsum;  // ASCII running word sum, residual after check word
    t_byte  pr_tens;
    t_byte  pr_chk_lo;
    logic   pr_net_mode;

    t_result tag_q [$];    // tags still owed by the DUT, oldest first
    t_pin    pin_q [$];    // per offered byte: hand-written tag or none
    t_byte   frame_bytes [$];

    int  fail_cnt = 0;
    logic cur_mode = 1'b0;  // net_mode as last written by the stimulus
    bit  no_idle = 1'b0;
    bit  hold_req = 1'b0;

    // Tag one accepted byte and advance the model state.
    function automatic t_result tag_byte(input t_byte b);
        t_result r;
        int unsigned hlen, p, e, cnt;
        logic bad;
        r = '0;
        r.out_byte = b;
        r.byte_kind = KIND_JUNK;
        bad = 1'b0;
        if (pr_phase == PH_HUNT) begin
            if (b == SOF_BIN || b == SOF_ASCII) begin
                pr_ascii = (b == SOF_ASCII);
                pr_bsum = b;
                pr_wsum = '0;
                pr_pos = 9'd1;
                pr_len = '0;
                pr_phase = PH_FRAME;
                r.byte_kind = pr_ascii ? KIND_ASCII : KIND_BIN;
                r.first_of_frame = 1'b1;
            end
        end else if (!pr_ascii) begin
            // header length follows net_mode as it is now, even mid-frame
            hlen = BASIC_HEADER_LEN + pr_net_mode;
            p = pr_pos;
            r.byte_kind = KIND_BIN;
            pr_bsum = pr_bsum + b;
            if (pr_len == 0 && p + 1 >= hlen)
                pr_len = t_len'(hlen + b);
            r.frame_length = pr_len;
            if (pr_len != 0 && p + 1 >= pr_len) begin
                r.last_of_frame = 1'b1;
                r.checksum_good = (pr_bsum == 8'd0);
                pr_phase = PH_HUNT;
            end else begin
                pr_pos = pr_pos + 9'd1;
            end
        end else begin
            p = pr_pos;
            r.byte_kind = KIND_ASCII;
            if (p == 1) begin
                if (b < DIGIT_ZERO || b > DIGIT_ONE)
                    bad = 1'b1;
                else
                    pr_tens = b;
            end else if (p == 2) begin
                if (b < DIGIT_ZERO || b > DIGIT_NINE) begin
                    bad = 1'b1;
                end else begin
                    cnt = (pr_tens - DIGIT_ZERO) * 10 + (b - DIGIT_ZERO);
                    pr_len = t_len'(ASCII_HEADER_LEN + cnt * RECORD_LEN + TRAILER_LEN);
                end
            end
            if (bad) begin
                r.byte_kind = KIND_ERR;
                pr_phase = PH_HUNT;
                pr_len = '0;
            end else begin
                e = pr_len;
                if (p >= 1 && (e == 0 || p + 5 <= e))
                    pr_wsum = pr_wsum + b;
                if (e != 0 && p + 4 == e)
                    pr_chk_lo = b;
                if (e != 0 && p + 3 == e)
                    pr_wsum = pr_wsum - {b, pr_chk_lo};
                r.frame_length = pr_len;
                if (e != 0 && p + 1 >= e) begin
                    r.last_of_frame = 1'b1;
                    r.checksum_good = (pr_wsum == 16'd0);
                    pr_phase = PH_HUNT;
                end else begin
                    pr_pos = pr_pos + 9'd1;
                end
            end
        end
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_cnt++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Monitor: everything is sampled at the rising edge, before the DUT's
    // and the drivers' nonblocking updates land.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : monitor
        t_result want;
        t_pin    pin;
        if (!rst_n) begin
            pr_phase = PH_HUNT;
            pr_ascii = 1'b0;
            pr_pos = '0;
            pr_len = '0;
            pr_bsum = '0;
            pr_wsum = '0;
            pr_tens = '0;
            pr_chk_lo = '0;
            pr_net_mode = 1'b0;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready)
                pr_net_mode = cfg_ch.net_mode;
            if (in_ch.valid && in_ch.ready) begin
                want = tag_byte(in_ch.in_byte);
                if (pin_q.size() != 0) begin
                    pin = pin_q.pop_front();
                    if (pin.pinned)
                        want = pin.val;
                end
                tag_q = {tag_q, want};
            end
            if (out_ch.valid && out_ch.ready) begin
                if (tag_q.size() == 0) begin
                    $error("result transaction with nothing outstanding, byte 0x%0h",
                           out_ch.out_byte);
                    fail_cnt++;
                end else begin
                    want = tag_q.pop_front();
                    check_field("out_byte", 32'(want.out_byte), 32'(out_ch.out_byte));
                    check_field("byte_kind", 32'(want.byte_kind),
                                32'(out_ch.byte_kind));
                    check_field("first_of_frame", 32'(want.first_of_frame),
                                32'(out_ch.first_of_frame));
                    check_field("last_of_frame", 32'(want.last_of_frame),
                                32'(out_ch.last_of_frame));
                    check_field("frame_length", 32'(want.frame_length),
                                32'(out_ch.frame_length));
                    check_field("checksum_good", 32'(want.checksum_good),
                                32'(out_ch.checksum_good));
                end
            end
        end
    end

    // Watchdog: too long without any transaction on any channel.
    always @(posedge clk) begin : watchdog
        int unsigned quiet;
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result sink: random back-pressure, plus one long hold-off so that the
    // DUT fills up and stalls its input while the source keeps offering.
    // ------------------------------------------------------------------------
    initial begin : sink_side
        int unsigned held;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++)
                    @(posedge clk);
                hold_req = 1'b0;
            end
            out_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------------
    // Source side helpers
    // ------------------------------------------------------------------------
    // Offer one byte, with random idle cycles first; returns at acceptance.
    task automatic send_byte(input t_byte b, input logic pinned, input t_result val);
        t_pin pin;
        pin.pinned = pinned;
        pin.val = val;
        if (!no_idle) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                in_ch.valid <= 1'b0;
                @(posedge clk);
            end
        end
        pin_q = {pin_q, pin};
        in_ch.valid <= 1'b1;
        in_ch.in_byte <= b;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    // Stop offering and wait until every owed tag has come back.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (tag_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_net_mode(input logic mode);
        cfg_ch.valid <= 1'b1;
        cfg_ch.net_mode <= mode;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        cur_mode = mode;
    endtask

    // Append one byte to the pending stream.
    function automatic void add_byte(input t_byte b);
        frame_bytes = {frame_bytes, b};
    endfunction

    // Append one random piece of stream: a binary frame, an ASCII frame,
    // junk, or a frame broken in its count field.
    task automatic queue_frame();
        int unsigned pick, hl, plen, cnt, flen, i;
        t_byte sum, x;
        logic [15:0] wsum, chk;
        logic good;
        pick = $urandom_range(99);
        good = ($urandom_range(99) < 80);
        if (pick < 55) begin
            hl = BASIC_HEADER_LEN + cur_mode;
            plen = ($urandom_range(99) < 85) ? $urandom_range(12) : $urandom_range(255);
            add_byte(SOF_BIN);
            sum = SOF_BIN;
            for (i = 1; i < hl - 1; i++) begin
                x = t_byte'($urandom_range(255));
                add_byte(x);
                sum += x;
            end
            add_byte(t_byte'(plen));
            sum += t_byte'(plen);
            for (i = 0; i < plen; i++) begin
                x = (good && i == plen - 1) ? t_byte'(-sum) : t_byte'($urandom_range(255));
                add_byte(x);
                sum += x;
            end
            // empty payload: the last header filler balances the sum
            if (plen == 0 && good)
                frame_bytes[frame_bytes.size() - 2] -= sum;
        end else if (pick < 88) begin
            cnt = ($urandom_range(99) < 92) ? $urandom_range(2) : $urandom_range(19);
            flen = ASCII_HEADER_LEN + cnt * RECORD_LEN + TRAILER_LEN;
            add_byte(SOF_ASCII);
            add_byte(t_byte'(DIGIT_ZERO + cnt / 10));
            add_byte(t_byte'(DIGIT_ZERO + cnt % 10));
            wsum = 16'((DIGIT_ZERO + cnt / 10) + (DIGIT_ZERO + cnt % 10));
            for (i = 3; i <= flen - 5; i++) begin
                x = t_byte'($urandom_range(255));
                add_byte(x);
                wsum += x;
            end
            chk = good ? wsum : 16'($urandom_range(16'hFFFF));
            add_byte(chk[7:0]);
            add_byte(chk[15:8]);
            add_byte(t_byte'($urandom_range(255)));
            add_byte(t_byte'($urandom_range(255)));
        end else if (pick < 95) begin
            cnt = $urandom_range(1, 8);
            for (i = 0; i < cnt; i++)
                add_byte(t_byte'($urandom_range(255)));
        end else begin
            // broken count field: bad tens digit, or good tens and bad units
            add_byte(SOF_ASCII);
            if ($urandom_range(1) == 0) begin
                do x = t_byte'($urandom_range(255));
                while (x >= DIGIT_ZERO && x <= DIGIT_ONE);
            end else begin
                add_byte($urandom_range(1) ? DIGIT_ONE : DIGIT_ZERO);
                do x = t_byte'($urandom_range(255));
                while (x >= DIGIT_ZERO && x <= DIGIT_NINE);
            end
            add_byte(x);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int unsigned sent, next_switch;
        rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.in_byte <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.net_mode <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_net_mode(1'b0);

        for (int i = 0; i < N_PLAN; i++) begin
            if (plan[i].mode != cur_mode) begin
                drain();
                set_net_mode(plan[i].mode);
            end
            send_byte(plan[i].data, plan[i].pinned, plan[i].val);
        end

        // random stream; net_mode changes between phases, often mid-frame
        sent = N_PLAN;
        next_switch = sent + $urandom_range(100, 300);
        while (sent < TOTAL_ITEMS) begin
            if (sent == next_switch) begin
                drain();
                set_net_mode(1'($urandom_range(1)));
                next_switch = sent + $urandom_range(100, 300);
            end
            no_idle = (sent >= QUIET_FROM && sent < QUIET_TO);
            if (sent == HOLD_AT)
                hold_req = 1'b1;
            if (frame_bytes.size() == 0)
                queue_frame();
            send_byte(frame_bytes.pop_front(), 1'b0, '0);
            sent++;
        end

        drain();
        if (fail_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
